// File: hdl/lbf_pkg.sv
// lbf_pkg: types, constants and the pattern step function of the led pattern controller
// no dependencies; used by every module of the block
package lbf_pkg;

  // number of led channels and their index width
  localparam int NUM_LEDS  = 2;
  localparam int LED_IDX_W = (NUM_LEDS > 1) ? $clog2(NUM_LEDS) : 1;

  // results one tick may cause
  localparam int MAX_OUT    = 2;
  localparam int PEND_IDX_W = (MAX_OUT > 1) ? $clog2(MAX_OUT) : 1;
  localparam int CNT_W      = $clog2(MAX_OUT + 1);

  // command queue between front and back
  localparam int OPQ_DEPTH = 2;
  localparam int OPQ_PTR_W = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
  localparam int OPQ_CNT_W = $clog2(OPQ_DEPTH + 1);

  localparam logic [6:0]  FULL_LEVEL    = 7'd100;
  localparam logic [19:0] PWM_PERIOD_NS = 20'd1000000;

  // cycle_ms / 100 as (cycle_ms * 83887) >> 23, exact over 16 bits
  localparam logic [16:0] FADE_RECIP = 17'd83887;
  localparam int          FADE_SHIFT = 23;

  typedef enum logic [1:0] {
    REQ_TICK   = 2'd0,
    REQ_STATIC = 2'd1,
    REQ_BLINK  = 2'd2,
    REQ_FADE   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    MODE_STATIC = 2'd0,
    MODE_BLINK  = 2'd1,
    MODE_FADE   = 2'd2
  } mode_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic        led_select;
    logic [7:0]  level_percent;
    logic [15:0] cycle_ms;
  } in_item_t;

  typedef struct packed {
    logic        led_channel;
    logic [6:0]  brightness;
    logic [19:0] pulse_ns;
    logic        last;
  } out_item_t;

  // classified request as queued for the back end
  typedef struct packed {
    req_t        kind;
    logic        led;
    logic [6:0]  level;
    logic [15:0] interval;
  } op_t;

  typedef struct packed {
    logic full;
    logic empty;
  } opq_status_t;

  typedef struct packed {
    logic [6:0] level;
    logic       up;
  } step_t;

  // one step of a blink or fade pattern
  function automatic step_t pattern_step(input mode_t m, input logic [6:0] lv, input logic up);
    step_t      s;
    logic [6:0] l;
    logic       u;
    l = (lv > FULL_LEVEL) ? FULL_LEVEL : lv;
    u = up;
    if (m == MODE_BLINK) begin
      s.level = (lv != 7'd0) ? 7'd0 : FULL_LEVEL;
      s.up    = up;
    end else begin
      if ((l == 7'd0) || (l == FULL_LEVEL)) u = ~u;
      s.level = u ? (l + 7'd1) : (l - 7'd1);
      s.up    = u;
    end
    return s;
  endfunction

endpackage

// File: hdl/lbf_front.sv
// lbf_front: accepts request items, drops unknown leds and works out the step interval
// depends on lbf_pkg
module lbf_front (
  input  logic              in_valid,
  output logic              in_ready,
  input  lbf_pkg::in_item_t in_data,
  input  lbf_pkg::opq_status_t q_status,
  output logic              push,
  output lbf_pkg::op_t      push_op
);

  logic        is_tick;
  logic        led_ok;
  logic [32:0] fade_prod;
  logic [15:0] iv_raw;

  assign in_ready = ~q_status.full;
  assign is_tick  = (lbf_pkg::req_t'(in_data.req_type) == lbf_pkg::REQ_TICK);
  assign led_ok   = (32'(in_data.led_select) < lbf_pkg::NUM_LEDS);

  // items that change nothing never enter the queue
  assign push = in_valid & in_ready & (is_tick | led_ok);

  assign fade_prod = 33'(in_data.cycle_ms) * 33'(lbf_pkg::FADE_RECIP);

  always_comb begin
    if (lbf_pkg::req_t'(in_data.req_type) == lbf_pkg::REQ_BLINK) begin
      iv_raw = {1'b0, in_data.cycle_ms[15:1]};
    end else begin
      iv_raw = 16'(fade_prod >> lbf_pkg::FADE_SHIFT);
    end
    push_op.kind     = lbf_pkg::req_t'(in_data.req_type);
    push_op.led      = in_data.led_select;
    push_op.level    = (in_data.level_percent > 8'(lbf_pkg::FULL_LEVEL)) ?
                       lbf_pkg::FULL_LEVEL : in_data.level_percent[6:0];
    // short cycle: never below one tick
    push_op.interval = (iv_raw == 16'd0) ? 16'd1 : iv_raw;
  end

endmodule

// File: hdl/lbf_op_fifo.sv
// lbf_op_fifo: short queue of classified requests between front and back
// depends on lbf_pkg
module lbf_op_fifo (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  lbf_pkg::op_t         push_op,
  input  logic                 pop,
  output lbf_pkg::op_t         head_op,
  output lbf_pkg::opq_status_t status
);

  lbf_pkg::op_t                  q_r [lbf_pkg::OPQ_DEPTH];
  logic [lbf_pkg::OPQ_PTR_W-1:0] wr_r, wr_nxt;
  logic [lbf_pkg::OPQ_PTR_W-1:0] rd_r, rd_nxt;
  logic [lbf_pkg::OPQ_CNT_W-1:0] cnt_r, cnt_nxt;

  function automatic logic [lbf_pkg::OPQ_PTR_W-1:0] ptr_inc(
    input logic [lbf_pkg::OPQ_PTR_W-1:0] p);
    if (32'(p) == lbf_pkg::OPQ_DEPTH - 1) return '0;
    return lbf_pkg::OPQ_PTR_W'(p + 1'b1);
  endfunction

  assign head_op      = q_r[rd_r];
  assign status.full  = (32'(cnt_r) == lbf_pkg::OPQ_DEPTH);
  assign status.empty = (cnt_r == '0);

  always_comb begin
    wr_nxt  = push ? ptr_inc(wr_r) : wr_r;
    rd_nxt  = pop ? ptr_inc(rd_r) : rd_r;
    cnt_nxt = cnt_r;
    if (push && !pop) cnt_nxt = lbf_pkg::OPQ_CNT_W'(cnt_r + 1'b1);
    if (pop && !push) cnt_nxt = lbf_pkg::OPQ_CNT_W'(cnt_r - 1'b1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) q_r[wr_r] <= push_op;
  end

endmodule

// File: hdl/lbf_back.sv
// lbf_back: per-led pattern state, executes queued requests and drives the result register
// depends on lbf_pkg
module lbf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               op_valid,
  input  lbf_pkg::op_t       op,
  output logic               pop,
  output logic               out_valid,
  input  logic               out_ready,
  output lbf_pkg::out_item_t out_data
);

  lbf_pkg::mode_t mode_r [lbf_pkg::NUM_LEDS];
  lbf_pkg::mode_t mode_nxt [lbf_pkg::NUM_LEDS];
  logic [6:0]     level_r [lbf_pkg::NUM_LEDS];
  logic [6:0]     level_nxt [lbf_pkg::NUM_LEDS];
  logic           up_r [lbf_pkg::NUM_LEDS];
  logic           up_nxt [lbf_pkg::NUM_LEDS];
  logic [15:0]    interval_r [lbf_pkg::NUM_LEDS];
  logic [15:0]    interval_nxt [lbf_pkg::NUM_LEDS];
  logic [15:0]    countdown_r [lbf_pkg::NUM_LEDS];
  logic [15:0]    countdown_nxt [lbf_pkg::NUM_LEDS];

  // results waiting for the output register
  logic           pend_ch_r [lbf_pkg::MAX_OUT];
  logic           pend_ch_nxt [lbf_pkg::MAX_OUT];
  logic [6:0]     pend_lvl_r [lbf_pkg::MAX_OUT];
  logic [6:0]     pend_lvl_nxt [lbf_pkg::MAX_OUT];
  logic [lbf_pkg::CNT_W-1:0]      pend_left_r, pend_left_nxt;
  logic [lbf_pkg::PEND_IDX_W-1:0] pend_head_r, pend_head_nxt;

  logic               out_valid_r, out_valid_nxt;
  lbf_pkg::out_item_t out_data_r, out_data_nxt;

  logic                          move;
  logic [lbf_pkg::CNT_W-1:0]     cnt;
  logic [lbf_pkg::LED_IDX_W-1:0] led_idx;
  lbf_pkg::step_t                st;
  logic [6:0]                    head_lvl;
  logic [13:0]                   sq;
  logic [19:0]                   sq_w;

  assign move = (pend_left_r != '0) & (~out_valid_r | out_ready);
  assign pop  = op_valid & ((pend_left_r == '0) |
                            ((pend_left_r == lbf_pkg::CNT_W'(1)) & move));

  assign head_lvl = pend_lvl_r[pend_head_r];
  assign sq       = 14'(head_lvl) * 14'(head_lvl);
  assign sq_w     = 20'(sq);

  always_comb begin
    mode_nxt      = mode_r;
    level_nxt     = level_r;
    up_nxt        = up_r;
    interval_nxt  = interval_r;
    countdown_nxt = countdown_r;
    pend_ch_nxt   = pend_ch_r;
    pend_lvl_nxt  = pend_lvl_r;
    pend_left_nxt = pend_left_r;
    pend_head_nxt = pend_head_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    cnt           = '0;
    led_idx       = lbf_pkg::LED_IDX_W'(op.led);
    st            = '0;

    // hand the head result to the output register
    if (move) begin
      out_valid_nxt            = 1'b1;
      out_data_nxt.led_channel = pend_ch_r[pend_head_r];
      out_data_nxt.brightness  = head_lvl;
      out_data_nxt.pulse_ns    = lbf_pkg::PWM_PERIOD_NS -
                                 ((sq_w << 6) + (sq_w << 5) + (sq_w << 2));
      out_data_nxt.last        = (pend_left_r == lbf_pkg::CNT_W'(1));
      pend_left_nxt            = lbf_pkg::CNT_W'(pend_left_r - 1'b1);
      pend_head_nxt            = lbf_pkg::PEND_IDX_W'(pend_head_r + 1'b1);
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end

    if (pop) begin
      pend_head_nxt = '0;
      if (op.kind == lbf_pkg::REQ_TICK) begin
        for (int i = 0; i < lbf_pkg::NUM_LEDS; i++) begin
          if (((mode_r[i] == lbf_pkg::MODE_BLINK) || (mode_r[i] == lbf_pkg::MODE_FADE)) &&
              (32'(cnt) < lbf_pkg::MAX_OUT)) begin
            if (countdown_r[i] > 16'd1) begin
              countdown_nxt[i] = countdown_r[i] - 16'd1;
            end else begin
              st               = lbf_pkg::pattern_step(mode_r[i], level_r[i], up_r[i]);
              level_nxt[i]     = st.level;
              up_nxt[i]        = st.up;
              countdown_nxt[i] = interval_r[i];
              pend_ch_nxt[cnt[lbf_pkg::PEND_IDX_W-1:0]]  = 1'(i);
              pend_lvl_nxt[cnt[lbf_pkg::PEND_IDX_W-1:0]] = st.level;
              cnt = lbf_pkg::CNT_W'(cnt + 1'b1);
            end
          end
        end
        pend_left_nxt = cnt;
      end else begin
        if (op.kind == lbf_pkg::REQ_STATIC) begin
          mode_nxt[led_idx]  = lbf_pkg::MODE_STATIC;
          level_nxt[led_idx] = op.level;
          pend_lvl_nxt[0]    = op.level;
        end else begin
          mode_nxt[led_idx] = (op.kind == lbf_pkg::REQ_BLINK) ?
                              lbf_pkg::MODE_BLINK : lbf_pkg::MODE_FADE;
          st = lbf_pkg::pattern_step(mode_nxt[led_idx], 7'd0, 1'b0);
          level_nxt[led_idx]     = st.level;
          up_nxt[led_idx]        = st.up;
          interval_nxt[led_idx]  = op.interval;
          countdown_nxt[led_idx] = op.interval;
          pend_lvl_nxt[0]        = st.level;
        end
        pend_ch_nxt[0] = op.led;
        pend_left_nxt  = lbf_pkg::CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < lbf_pkg::NUM_LEDS; i++) begin
        mode_r[i]      <= lbf_pkg::MODE_STATIC;
        level_r[i]     <= '0;
        up_r[i]        <= 1'b0;
        interval_r[i]  <= '0;
        countdown_r[i] <= '0;
      end
      pend_left_r <= '0;
      pend_head_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      mode_r      <= mode_nxt;
      level_r     <= level_nxt;
      up_r        <= up_nxt;
      interval_r  <= interval_nxt;
      countdown_r <= countdown_nxt;
      pend_left_r <= pend_left_nxt;
      pend_head_r <= pend_head_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_ch_r  <= pend_ch_nxt;
    pend_lvl_r <= pend_lvl_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// File: hdl/led_blink_fade_pwm_controller_top.sv
// led_blink_fade_pwm_controller_top: top level of the two-channel led pattern controller
// depends on lbf_pkg, lbf_front, lbf_op_fifo, lbf_back
//
// Two-channel led pattern generator. A request item either sets one led to a
// static level, starts a blink or a fade pattern on it, or is a millisecond
// tick that advances every running pattern. Each level change gives one
// result item with the led, its level and the pwm pulse width
// 1000000 - 100*level^2 ns; a command always gives one result, a tick gives
// none, one or two, the final one marked with last. Items are taken at one a
// cycle as long as each causes at most one result and the result port does
// not stall; a tick with two results makes the next item wait until its
// first result has moved on, as the back end has a single result register.
// A two-entry queue parts the request side from the result side, so a
// stalled result port does not stop items being taken until the queue fills.
module led_blink_fade_pwm_controller_top (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  lbf_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output lbf_pkg::out_item_t out_data
);

  // front to queue
  logic                 push;
  lbf_pkg::op_t         push_op;
  lbf_pkg::opq_status_t q_status;

  // queue to back
  logic         pop;
  lbf_pkg::op_t head_op;

  // classification and interval division
  lbf_front u_front (
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .q_status (q_status),
    .push     (push),
    .push_op  (push_op)
  );

  // decoupling queue
  lbf_op_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .status  (q_status)
  );

  // pattern state and result delivery
  lbf_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .op_valid  (~q_status.empty),
    .op        (head_op),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// File: hdl/lbf_checker.sv
// lbf_checker: port-level assertions on the result channel of the led pattern controller
// depends on lbf_pkg; bound to led_blink_fade_pwm_controller_top
module lbf_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input lbf_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // reset empties the result register
  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.brightness <= lbf_pkg::FULL_LEVEL)
    else $error("brightness above full level");

  // pulse width follows the level shown with it
  a_pulse_match: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.pulse_ns == 20'(32'd1000000 -
      32'd100 * 32'(out_data.brightness) * 32'(out_data.brightness)))
    else $error("pulse width does not match brightness");

endmodule

bind led_blink_fade_pwm_controller_top lbf_checker u_lbf_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// File: tb/sv/tb_top.sv
// tb_top: self-checking bench for the two-channel led blink / fade pwm controller
// depends on lbf_pkg and led_blink_fade_pwm_controller_top; predicts every level change
// and checks each result item field by field against the oldest expected one
module tb_top;
  import lbf_pkg::*;

  // which side idles, and how often
  typedef enum int {
    PH_RX_BUSY,   // sender idles a little, receiver a lot
    PH_TX_BUSY,   // the other way round
    PH_NO_IDLE    // both sides run flat out, apart from one long receiver hold-off
  } idle_phase_t;

  localparam int RX_HOLD_CYCLES = 80;
  localparam int DRAIN_CYCLES   = 20;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_ready;
  in_item_t  in_data   = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_item_t out_data;

  idle_phase_t phase = PH_RX_BUSY;

  // request items waiting to be offered, and level changes waiting to come out
  in_item_t  pending_q[$];
  out_item_t level_changes_q[$];

  // predicted per-led pattern state
  mode_t       led_mode  [NUM_LEDS];
  logic [6:0]  led_level [NUM_LEDS];
  logic        led_rise  [NUM_LEDS];
  logic [15:0] led_period[NUM_LEDS];
  logic [15:0] led_wait  [NUM_LEDS];

  int items_taken    = 0;
  int results_seen   = 0;
  int double_ticks   = 0;
  int mismatches     = 0;

  led_blink_fade_pwm_controller_top DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // run limit, well above the slowest legal run
  initial begin
    #400000;
    $display("TB_ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------

  // percentage of cycles a side stays quiet in the current phase
  function automatic int idle_pct(input bit receiver);
    case (phase)
      PH_RX_BUSY: return receiver ? 45 : 18;
      PH_TX_BUSY: return receiver ? 18 : 45;
      default:    return 0;
    endcase
  endfunction

  // blink toggles between off and full; fade walks the triangle, turning at both ends
  function automatic void step_led(input int i);
    if (led_mode[i] == MODE_BLINK) begin
      led_level[i] = (led_level[i] != 7'd0) ? 7'd0 : FULL_LEVEL;
    end else begin
      if (led_level[i] > FULL_LEVEL) led_level[i] = FULL_LEVEL;
      if (led_level[i] == 7'd0 || led_level[i] == FULL_LEVEL) led_rise[i] = ~led_rise[i];
      led_level[i] = led_rise[i] ? led_level[i] + 7'd1 : led_level[i] - 7'd1;
    end
    led_wait[i] = led_period[i];
  endfunction

  // result item for the led's current level, with its pwm pulse width
  function automatic out_item_t level_item(input int i);
    out_item_t o;
    int        lv;
    lv            = int'(led_level[i]);
    o.led_channel = 1'(i);
    o.brightness  = led_level[i];
    o.pulse_ns    = 20'(int'(PWM_PERIOD_NS) - 100 * lv * lv);
    o.last        = 1'b0;
    return o;
  endfunction

  // update the predicted leds for one accepted request and queue what it causes
  function automatic void apply_request(input in_item_t it);
    out_item_t res[MAX_OUT];
    int        n;
    int        i;
    int        iv;
    n = 0;
    if (it.req_type == REQ_TICK) begin
      // one millisecond: every running pattern counts down, due ones step in led order
      for (i = 0; i < NUM_LEDS && n < MAX_OUT; i++) begin
        if (led_mode[i] == MODE_BLINK || led_mode[i] == MODE_FADE) begin
          if (led_wait[i] > 16'd1) begin
            led_wait[i] = led_wait[i] - 16'd1;
          end else begin
            step_led(i);
            res[n] = level_item(i);
            n++;
          end
        end
      end
      if (n == MAX_OUT) double_ticks++;
    end else if (int'(it.led_select) < NUM_LEDS) begin
      i = int'(it.led_select);
      if (it.req_type == REQ_STATIC) begin
        led_mode[i]  = MODE_STATIC;
        led_level[i] = (it.level_percent > 8'(FULL_LEVEL)) ? FULL_LEVEL : it.level_percent[6:0];
      end else begin
        // blink: half a cycle per toggle; fade: a hundredth per step; never below one tick
        iv = (it.req_type == REQ_BLINK) ? int'(it.cycle_ms) / 2 : int'(it.cycle_ms) / 100;
        if (iv == 0) iv = 1;
        led_mode[i]   = (it.req_type == REQ_BLINK) ? MODE_BLINK : MODE_FADE;
        led_level[i]  = 7'd0;
        led_rise[i]   = 1'b0;
        led_period[i] = 16'(iv);
        step_led(i);
      end
      res[0] = level_item(i);
      n = 1;
    end
    if (n > 0) res[n-1].last = 1'b1;
    for (i = 0; i < n; i++) level_changes_q.push_back(res[i]);
  endfunction

  // ---------------------------------------------------------------------------
  // driver: offers pending items, predicts on every accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      for (int i = 0; i < NUM_LEDS; i++) begin
        led_mode[i]   = MODE_STATIC;
        led_level[i]  = 7'd0;
        led_rise[i]   = 1'b0;
        led_period[i] = 16'd0;
        led_wait[i]   = 16'd0;
      end
    end else begin
      if (in_valid && in_ready) begin
        apply_request(in_data);
        items_taken++;
      end
      // payload only moves once the current item has gone
      if (!in_valid || in_ready) begin
        if (pending_q.size() != 0 && $urandom_range(0, 99) >= idle_pct(1'b0)) begin
          in_data  <= pending_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver ready, with one long hold-off at the start of the no-idle phase
  // ---------------------------------------------------------------------------
  int stall_left = 0;
  bit stall_done = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (stall_left != 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (phase == PH_NO_IDLE && !stall_done) begin
      // sender keeps offering meanwhile, so the block fills and drops in_ready
      out_ready  <= 1'b0;
      stall_left <= RX_HOLD_CYCLES;
      stall_done <= 1'b1;
    end else begin
      out_ready <= ($urandom_range(0, 99) >= idle_pct(1'b1));
    end
  end

  // ---------------------------------------------------------------------------
  // monitor: every result against the oldest expected level change
  // ---------------------------------------------------------------------------
  function automatic void check_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      results_seen++;
      if (level_changes_q.size() == 0) begin
        $display("%0t: result with none expected, expected nothing, got %p", $time, out_data);
        mismatches++;
      end else begin
        want = level_changes_q.pop_front();
        check_field("led_channel", want.led_channel, out_data.led_channel);
        check_field("brightness",  want.brightness,  out_data.brightness);
        check_field("pulse_ns",    want.pulse_ns,    out_data.pulse_ns);
        check_field("last",        want.last,        out_data.last);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------------
  function automatic in_item_t make_item(input req_t r, input logic led,
                                         input logic [7:0] pct, input logic [15:0] cyc);
    in_item_t it;
    it.req_type      = r;
    it.led_select    = led;
    it.level_percent = pct;
    it.cycle_ms      = cyc;
    return it;
  endfunction

  // tick with junk in the fields it ignores
  function automatic in_item_t noisy_tick();
    return make_item(REQ_TICK, 1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                     16'($urandom));
  endfunction

  // bursts of one command then a run of ticks; some runs are long enough for a
  // fast fade to reach full and turn back down
  task automatic add_random_bursts(input int target);
    int       n;
    int       run;
    bit       long_run;
    req_t     r;
    logic     led;
    logic [15:0] cyc;
    n = 0;
    while (n < target) begin
      long_run = ($urandom_range(0, 5) == 0);
      led      = 1'($urandom_range(0, 1));
      if (long_run) begin
        r   = REQ_FADE;
        cyc = 16'($urandom_range(0, 199));
      end else begin
        r   = req_t'($urandom_range(1, 3));
        cyc = ($urandom_range(0, 9) == 0) ? 16'($urandom) : 16'($urandom_range(0, 400));
      end
      pending_q.push_back(make_item(r, led, 8'($urandom_range(0, 255)), cyc));
      n++;
      run = long_run ? $urandom_range(120, 230) : $urandom_range(0, 30);
      repeat (run) pending_q.push_back(noisy_tick());
      n += run;
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // directed: nothing due after reset, static extremes and saturation
    pending_q.push_back(make_item(REQ_TICK,   1'b0, 8'd0,   16'd0));
    pending_q.push_back(make_item(REQ_STATIC, 1'b0, 8'd0,   16'd0));
    pending_q.push_back(make_item(REQ_STATIC, 1'b1, 8'd255, 16'd0));
    pending_q.push_back(make_item(REQ_STATIC, 1'b0, 8'd100, 16'd0));
    pending_q.push_back(make_item(REQ_STATIC, 1'b1, 8'd101, 16'd0));
    // short blink cycles raised to one tick, so each tick gives two results
    pending_q.push_back(make_item(REQ_BLINK,  1'b0, 8'd0,   16'd0));
    pending_q.push_back(make_item(REQ_BLINK,  1'b1, 8'd0,   16'd3));
    pending_q.push_back(make_item(REQ_TICK,   1'b0, 8'd0,   16'd0));
    pending_q.push_back(make_item(REQ_TICK,   1'b1, 8'd255, 16'hffff));
    // short fade cycle next to a running blink
    pending_q.push_back(make_item(REQ_FADE,   1'b1, 8'd0,   16'd99));
    repeat (3) pending_q.push_back(make_item(REQ_TICK, 1'b0, 8'd0, 16'd0));
    // longest cycles
    pending_q.push_back(make_item(REQ_FADE,   1'b0, 8'd0,   16'hffff));
    pending_q.push_back(make_item(REQ_TICK,   1'b0, 8'd0,   16'd0));
    pending_q.push_back(make_item(REQ_BLINK,  1'b1, 8'd0,   16'hffff));
    repeat (2) pending_q.push_back(make_item(REQ_TICK, 1'b0, 8'd0, 16'd0));
    // fade stepping every second tick
    pending_q.push_back(make_item(REQ_FADE,   1'b0, 8'd0,   16'd250));
    repeat (3) pending_q.push_back(make_item(REQ_TICK, 1'b0, 8'd0, 16'd0));
    // back to static with the ignored fields all ones
    pending_q.push_back(make_item(REQ_STATIC, 1'b0, 8'd50,  16'hffff));
    pending_q.push_back(make_item(REQ_STATIC, 1'b1, 8'd7,   16'hffff));
    pending_q.push_back(make_item(REQ_TICK,   1'b1, 8'hff,  16'hffff));

    add_random_bursts(420);
    while (pending_q.size() != 0) @(posedge clk);

    phase = PH_TX_BUSY;
    add_random_bursts(420);
    while (pending_q.size() != 0) @(posedge clk);

    add_random_bursts(420);
    phase = PH_NO_IDLE;

    // everything accepted, then everything out, then a quiet margin
    while (pending_q.size() != 0 || in_valid) @(posedge clk);
    while (level_changes_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d request items under three idling mixes, %0d results checked,",
             items_taken, results_seen);
    $display("%0d ticks stepping both leds, %0d mismatches", double_ticks, mismatches);
    if (mismatches == 0 && level_changes_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// File: sim.f
hdl/lbf_pkg.sv
hdl/lbf_front.sv
hdl/lbf_op_fifo.sv
hdl/lbf_back.sv
hdl/led_blink_fade_pwm_controller_top.sv
hdl/lbf_checker.sv
tb/sv/tb_top.sv
